// ===== rtl/rrip_ship_stream_replacement_core_assert.svh =====
// Assertion macros for the replacement core.
// Define NO_ASSERTIONS to compile every check away.
`ifndef RRIP_SHIP_STREAM_REPLACEMENT_CORE_ASSERT_SVH
`define RRIP_SHIP_STREAM_REPLACEMENT_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Clocked check, quiet while reset is asserted.
`define RSS_ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked check that also holds while reset is asserted.
`define RSS_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RSS_ASSERT_CLK(label, prop, msg)
`define RSS_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

// ===== rtl/rrip_ss_pkg.sv =====
// Shared types, constants and the signature hash of the replacement core.
// No dependencies.
`default_nettype none

package rrip_ss_pkg;

    localparam int BLOCK_SHIFT = 6;
    localparam int BLK_W       = 58;
    localparam int SIG_W       = 6;
    localparam int SIG_ENTRIES = 64;
    localparam int CTR_ROW_W   = 2 * SIG_ENTRIES;

    localparam logic OP_FIND   = 1'b0;
    localparam logic OP_UPDATE = 1'b1;

    localparam logic [1:0] RRPV_MAX     = 2'd3;
    localparam logic [1:0] RRPV_DISTANT = 2'd2;
    localparam logic [1:0] RRPV_NEAR    = 2'd0;
    localparam logic [1:0] CTR_MAX      = 2'd3;
    localparam logic [1:0] CTR_INIT     = 2'd1;
    localparam logic [1:0] CTR_REUSE    = 2'd2;
    localparam logic [1:0] STREAM_MAX   = 2'd3;
    localparam logic [1:0] STREAM_ON    = 2'd2;

    typedef struct packed {
        logic        opcode;
        logic [10:0] set_index;
        logic [3:0]  way_index;
        logic [15:0] valid_mask;
        logic [17:0] pc_low;
        logic [63:0] phys_addr;
        logic        was_hit;
    } req_t;

    typedef struct packed {
        logic [3:0] victim_way;
        logic [1:0] new_rrpv;
        logic       set_streaming;
    } rsp_t;

    // Fold the low PC bits into a 6-bit signature.
    function automatic logic [SIG_W-1:0] pc_hash(input logic [17:0] pc);
        logic [17:0] h;
        h = pc ^ (pc >> 6) ^ (pc >> 12);
        return h[SIG_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/rrip_ss_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module rrip_ss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                     clk,
    input  wire logic                                     rd_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                         rd_data,
    input  wire logic                                     wr_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                         wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/rrip_ss_policy.sv =====
// Row update logic: victim search with aging, stream detection, signature
// counter training and insertion RRPV. Depends on rrip_ss_pkg.
`default_nettype none

module rrip_ss_policy #(
    parameter int NUM_WAYS = 16
) (
    input  wire rrip_ss_pkg::req_t              item,
    input  wire logic [2*NUM_WAYS-1:0]          rrpv_in,
    input  wire logic [rrip_ss_pkg::CTR_ROW_W-1:0] ctr_in,
    input  wire logic [1:0]                     stream_in,
    input  wire logic [rrip_ss_pkg::BLK_W-1:0]  last_addr_in,
    input  wire logic                           last_valid_in,
    output logic      [2*NUM_WAYS-1:0]          rrpv_out,
    output logic      [rrip_ss_pkg::CTR_ROW_W-1:0] ctr_out,
    output logic      [1:0]                     stream_out,
    output logic      [rrip_ss_pkg::BLK_W-1:0]  last_addr_out,
    output logic                                last_valid_out,
    output rrip_ss_pkg::rsp_t                   result
);

    localparam int WAY_W  = $clog2(NUM_WAYS);
    localparam int WIDX_W = (WAY_W > 4) ? WAY_W : 4;
    localparam int VM_W   = (NUM_WAYS > 16) ? NUM_WAYS : 16;

    logic [VM_W-1:0]                    valid_ext;
    logic                               any_inv;
    logic [WIDX_W-1:0]                  inv_idx;
    logic                               any3;
    logic                               any2;
    logic                               any1;
    logic [1:0]                         top;
    logic [1:0]                         age;
    logic [2:0]                         sum;
    logic [2*NUM_WAYS-1:0]              aged_row;
    logic [WIDX_W-1:0]                  top_idx;
    logic [rrip_ss_pkg::BLK_W-1:0]      blk;
    logic                               near;
    logic [1:0]                         stream_new;
    logic                               streaming;
    logic [rrip_ss_pkg::SIG_W-1:0]      sig;
    logic [1:0]                         ctr_old;
    logic [1:0]                         ctr_new;
    logic [rrip_ss_pkg::CTR_ROW_W-1:0]  ctr_upd;
    logic [1:0]                         rr_new;
    logic [WIDX_W-1:0]                  way_ext;
    logic [2*NUM_WAYS-1:0]              rrpv_upd;

    // Victim search: first invalid way, else age the set and take the first
    // way that reaches the maximum RRPV.
    always_comb
    begin
        valid_ext       = '1;
        valid_ext[15:0] = item.valid_mask;
        any_inv         = 1'b0;
        inv_idx         = '0;
        for (int w = NUM_WAYS - 1; w >= 0; w--)
        begin
            if (!valid_ext[w])
            begin
                any_inv = 1'b1;
                inv_idx = WIDX_W'(w);
            end
        end

        any3 = 1'b0;
        any2 = 1'b0;
        any1 = 1'b0;
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            any3 = any3 | (rrpv_in[2*w +: 2] == 2'd3);
            any2 = any2 | (rrpv_in[2*w +: 2] == 2'd2);
            any1 = any1 | (rrpv_in[2*w +: 2] == 2'd1);
        end
        top = any3 ? 2'd3 : (any2 ? 2'd2 : (any1 ? 2'd1 : 2'd0));
        age = rrip_ss_pkg::RRPV_MAX - top;

        top_idx = '0;
        for (int w = NUM_WAYS - 1; w >= 0; w--)
        begin
            if (rrpv_in[2*w +: 2] == top)
            begin
                top_idx = WIDX_W'(w);
            end
        end

        aged_row = rrpv_in;
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            sum = {1'b0, rrpv_in[2*w +: 2]} + {1'b0, age};
            aged_row[2*w +: 2] = (sum > 3'd3) ? rrip_ss_pkg::RRPV_MAX : sum[1:0];
        end
    end

    // Update: stream detector, signature counter, insertion RRPV.
    always_comb
    begin
        blk  = item.phys_addr[63:rrip_ss_pkg::BLOCK_SHIFT];
        near = (blk == last_addr_in)
            || ({1'b0, blk} == {1'b0, last_addr_in} + 59'd1)
            || ({1'b0, last_addr_in} == {1'b0, blk} + 59'd1);

        stream_new = stream_in;
        if (last_valid_in)
        begin
            if (near)
            begin
                if (stream_in != rrip_ss_pkg::STREAM_MAX)
                begin
                    stream_new = stream_in + 2'd1;
                end
            end
            else if (stream_in != 2'd0)
            begin
                stream_new = stream_in - 2'd1;
            end
        end
        streaming = (stream_new >= rrip_ss_pkg::STREAM_ON);

        sig     = rrip_ss_pkg::pc_hash(item.pc_low);
        ctr_old = ctr_in[{sig, 1'b0} +: 2];
        ctr_new = ctr_old;
        if (item.was_hit)
        begin
            if (ctr_old != rrip_ss_pkg::CTR_MAX)
            begin
                ctr_new = ctr_old + 2'd1;
            end
        end
        else if (ctr_old != 2'd0)
        begin
            ctr_new = ctr_old - 2'd1;
        end
        ctr_upd = ctr_in;
        ctr_upd[{sig, 1'b0} +: 2] = ctr_new;

        if (streaming)
        begin
            rr_new = rrip_ss_pkg::RRPV_MAX;
        end
        else if (ctr_new >= rrip_ss_pkg::CTR_REUSE)
        begin
            rr_new = rrip_ss_pkg::RRPV_NEAR;
        end
        else
        begin
            rr_new = rrip_ss_pkg::RRPV_DISTANT;
        end

        // A way index past the set's ways matches nothing: no RRPV write.
        way_ext  = WIDX_W'(item.way_index);
        rrpv_upd = rrpv_in;
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            if (WIDX_W'(w) == way_ext)
            begin
                rrpv_upd[2*w +: 2] = rr_new;
            end
        end
    end

    always_comb
    begin
        case (item.opcode)
            rrip_ss_pkg::OP_UPDATE:
            begin
                rrpv_out             = rrpv_upd;
                ctr_out              = ctr_upd;
                stream_out           = stream_new;
                last_addr_out        = blk;
                last_valid_out       = 1'b1;
                result.victim_way    = 4'd0;
                result.new_rrpv      = rr_new;
                result.set_streaming = streaming;
            end
            default:
            begin
                rrpv_out             = any_inv ? rrpv_in : aged_row;
                ctr_out              = ctr_in;
                stream_out           = stream_in;
                last_addr_out        = last_addr_in;
                last_valid_out       = last_valid_in;
                result.victim_way    = any_inv ? inv_idx[3:0] : top_idx[3:0];
                result.new_rrpv      = 2'd0;
                result.set_streaming = (stream_in >= rrip_ss_pkg::STREAM_ON);
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/rrip_ship_stream_replacement_core.sv =====
// Replacement core: 2-bit RRIP with per-set signature counters and stream
// detect. Uses rrip_ss_pkg, rrip_ss_ram, rrip_ss_policy and the assert header.
// A request's row is read into the RAM's read data register, and its result is
// registered in the modify state. A new request waits for the read-modify-write
// of the per-set row memory (read, then modify and write back) and for room
// in the result register. Reset: a clearing pass writes every row to its reset value.
`default_nettype none

`include "rrip_ship_stream_replacement_core_assert.svh"

module rrip_ship_stream_replacement_core #(
    parameter int NUM_SETS = 2048,
    parameter int NUM_WAYS = 16
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    output logic                   req_stall,
    input  wire rrip_ss_pkg::req_t req,
    output logic                   rsp_valid,
    input  wire logic              rsp_stall,
    output rrip_ss_pkg::rsp_t      rsp
);

    localparam int SET_W  = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int RRPV_W = 2 * NUM_WAYS;
    // Row layout, low to high: RRPVs, signature counters, stream counter,
    // last block address, last-address valid.
    localparam int CTR_LO = RRPV_W;
    localparam int STR_LO = CTR_LO + rrip_ss_pkg::CTR_ROW_W;
    localparam int ADR_LO = STR_LO + 2;
    localparam int LV_BIT = ADR_LO + rrip_ss_pkg::BLK_W;
    localparam int ROW_W  = LV_BIT + 1;

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_MOD   = 2'd2;

    logic [1:0]              state_reg;
    logic [1:0]              state_next;
    logic [SET_W-1:0]        clr_cnt_reg;
    logic [SET_W-1:0]        clr_cnt_next;
    rrip_ss_pkg::req_t       item_reg;
    logic [SET_W-1:0]        set_reg;
    rrip_ss_pkg::rsp_t       rsp_reg;
    logic                    rsp_valid_reg;
    logic                    rsp_valid_next;

    logic                    accept;
    logic [27:0]             set_rem;
    logic [SET_W-1:0]        set_mod;
    logic                    clr_last;

    logic [ROW_W-1:0]        rd_row;
    logic [ROW_W-1:0]        new_row;
    logic [ROW_W-1:0]        reset_row;
    logic                    wr_en;
    logic [SET_W-1:0]        wr_addr;
    logic [ROW_W-1:0]        wr_data;

    logic [RRPV_W-1:0]                    rrpv_new;
    logic [rrip_ss_pkg::CTR_ROW_W-1:0]    ctr_new;
    logic [1:0]                           stream_new;
    logic [rrip_ss_pkg::BLK_W-1:0]        last_addr_new;
    logic                                 last_valid_new;
    rrip_ss_pkg::rsp_t                    result;

    // Take a request only when idle and the result register has room by the
    // time the row comes back from memory.
    assign req_stall = !((state_reg == ST_IDLE) && (!rsp_valid_reg || !rsp_stall));
    assign accept    = req_valid && !req_stall;
    assign clr_last  = (clr_cnt_reg == SET_W'(NUM_SETS - 1));

    // Wrap the set index into range by restoring subtraction of scaled set
    // counts; steps whose scaled count exceeds the index range fold away.
    always_comb
    begin
        set_rem = 28'(req.set_index);
        for (int k = 10; k >= 0; k--)
        begin
            if (set_rem >= (28'(NUM_SETS) << k))
            begin
                set_rem = set_rem - (28'(NUM_SETS) << k);
            end
        end
        set_mod = set_rem[SET_W-1:0];
    end

    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                // Sweep every row once, then open for requests.
                clr_cnt_next = clr_cnt_reg + SET_W'(1);
                if (clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_MOD;
                end
            end
            ST_MOD:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Hold the request while its row is read.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= req;
            set_reg  <= set_mod;
        end
        if (state_reg == ST_MOD)
        begin
            rsp_reg <= result;
        end
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (state_reg == ST_MOD)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign reset_row = {1'b0,
                        {rrip_ss_pkg::BLK_W{1'b0}},
                        2'd0,
                        {rrip_ss_pkg::SIG_ENTRIES{rrip_ss_pkg::CTR_INIT}},
                        {NUM_WAYS{rrip_ss_pkg::RRPV_DISTANT}}};

    assign new_row = {last_valid_new, last_addr_new, stream_new, ctr_new, rrpv_new};

    // Write back the modified row; during the clearing pass write reset rows.
    assign wr_en   = (state_reg == ST_CLEAR) || (state_reg == ST_MOD);
    assign wr_addr = (state_reg == ST_CLEAR) ? clr_cnt_reg : set_reg;
    assign wr_data = (state_reg == ST_CLEAR) ? reset_row : new_row;

    rrip_ss_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NUM_SETS)
    ) u_row_ram (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (set_mod),
        .rd_data (rd_row),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    rrip_ss_policy #(
        .NUM_WAYS (NUM_WAYS)
    ) u_policy (
        .item           (item_reg),
        .rrpv_in        (rd_row[RRPV_W-1:0]),
        .ctr_in         (rd_row[STR_LO-1:CTR_LO]),
        .stream_in      (rd_row[ADR_LO-1:STR_LO]),
        .last_addr_in   (rd_row[LV_BIT-1:ADR_LO]),
        .last_valid_in  (rd_row[LV_BIT]),
        .rrpv_out       (rrpv_new),
        .ctr_out        (ctr_new),
        .stream_out     (stream_new),
        .last_addr_out  (last_addr_new),
        .last_valid_out (last_valid_new),
        .result         (result)
    );

    // No request may enter while reset holds the clearing pass.
    `RSS_ASSERT_ALWAYS(a_stall_in_reset, !rst_n |-> req_stall, "request open during reset")
    // An accepted request spends the next cycle modifying its row.
    `RSS_ASSERT_CLK(a_accept_to_mod, accept |=> (state_reg == ST_MOD) && req_stall, "no modify after transfer")
    // The modify cycle always leaves a result behind.
    `RSS_ASSERT_CLK(a_mod_to_rsp, (state_reg == ST_MOD) |=> rsp_valid, "modify without result")
    // No result can exist before the clearing pass ends.
    `RSS_ASSERT_CLK(a_clear_no_rsp, (state_reg == ST_CLEAR) |-> !rsp_valid, "result during clear")

endmodule

`default_nettype wire
